>>> rtl/veos_pkg.sv
package veos_pkg;

  // largest volume supported; the line and slice memories are sized by width and height
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MAX_DEPTH  = 1024;

  localparam int XW          = $clog2(MAX_WIDTH);
  localparam int YW          = $clog2(MAX_HEIGHT);
  localparam int ZW          = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int PLANE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW          = $clog2(PLANE_DEPTH);

  // field widths
  localparam int SAMPLE_W = 16;
  localparam int DIM_W    = 11;
  localparam int SUM_W    = 34;
  localparam int DSUM_W   = 8;

  // configuration port
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  localparam logic [2:0] REG_THR_LOW  = 3'd0;
  localparam logic [2:0] REG_THR_HIGH = 3'd1;
  localparam logic [2:0] REG_WIDTH    = 3'd2;
  localparam logic [2:0] REG_HEIGHT   = 3'd3;
  localparam logic [2:0] REG_DEPTH    = 3'd4;

  // euler contributions for odd octant codes 1, 3, ..., 255
  localparam logic signed [3:0] EULER_ODD [128] = '{
     4'sd1,  4'sd0,  4'sd0, -4'sd1, -4'sd2, -4'sd1, -4'sd1,  4'sd0,
     4'sd0, -4'sd1, -4'sd1, -4'sd2, -4'sd3, -4'sd2, -4'sd2, -4'sd1,
    -4'sd2, -4'sd1, -4'sd3, -4'sd2, -4'sd1, -4'sd2,  4'sd0, -4'sd1,
    -4'sd1,  4'sd0, -4'sd2, -4'sd1,  4'sd0, -4'sd1,  4'sd1,  4'sd0,
    -4'sd2, -4'sd3, -4'sd1, -4'sd2, -4'sd1,  4'sd0, -4'sd2, -4'sd1,
    -4'sd1, -4'sd2,  4'sd0, -4'sd1,  4'sd0,  4'sd1, -4'sd1,  4'sd0,
    -4'sd1,  4'sd0,  4'sd0,  4'sd1,  4'sd4,  4'sd3,  4'sd3,  4'sd2,
    -4'sd2, -4'sd1, -4'sd1,  4'sd0,  4'sd3,  4'sd2,  4'sd2,  4'sd1,
    -4'sd6, -4'sd3, -4'sd3,  4'sd0, -4'sd3, -4'sd2, -4'sd2, -4'sd1,
    -4'sd3,  4'sd0,  4'sd0,  4'sd3,  4'sd0,  4'sd1,  4'sd1,  4'sd2,
    -4'sd3, -4'sd2,  4'sd0,  4'sd1,  4'sd0, -4'sd1,  4'sd1,  4'sd0,
    -4'sd2, -4'sd1,  4'sd1,  4'sd2,  4'sd1,  4'sd0,  4'sd2,  4'sd1,
    -4'sd3,  4'sd0, -4'sd2,  4'sd1,  4'sd0,  4'sd1, -4'sd1,  4'sd0,
    -4'sd2,  4'sd1, -4'sd1,  4'sd2,  4'sd1,  4'sd2,  4'sd0,  4'sd1,
     4'sd0,  4'sd1,  4'sd1,  4'sd2,  4'sd3,  4'sd2,  4'sd2,  4'sd1,
    -4'sd1,  4'sd0,  4'sd0,  4'sd1,  4'sd2,  4'sd1,  4'sd1,  4'sd0
  };

  // rotate the octant so a foreground corner comes first, then look it up
  // corner k of the octant is bit k-1 of m
  function automatic logic signed [3:0] octant_delta(input logic [7:0] m);
    logic [7:0] n;
    logic signed [3:0] res;
    n = 8'd1;
    if (m[7]) begin
      n[7] = m[0]; n[6] = m[1]; n[5] = m[2]; n[4] = m[3];
      n[3] = m[4]; n[2] = m[5]; n[1] = m[6];
    end else if (m[6]) begin
      n[7] = m[1]; n[6] = m[3]; n[5] = m[0]; n[4] = m[2];
      n[3] = m[5]; n[1] = m[4];
    end else if (m[5]) begin
      n[7] = m[2]; n[6] = m[0]; n[5] = m[3]; n[4] = m[1];
      n[2] = m[4];
    end else if (m[4]) begin
      n[7] = m[3]; n[6] = m[2]; n[5] = m[1]; n[4] = m[0];
    end else if (m[3]) begin
      n[3] = m[0]; n[2] = m[2]; n[1] = m[1];
    end else if (m[2]) begin
      n[3] = m[1]; n[2] = m[0];
    end else if (m[1]) begin
      n[1] = m[0];
    end
    if (m == 8'd0) begin
      res = 4'sd0;
    end else begin
      res = EULER_ODD[n[7:1]];
    end
    return res;
  endfunction

endpackage

>>> rtl/voxel_euler_octant_sum_top.sv
// Streaming 3-D Euler sum: one signed voxel per cycle in raster order (x, then y, then z),
// foreground when strictly between the two thresholds. Every lattice vertex octant is
// rotated, looked up and added, and one beat carrying eight times the Euler number leaves
// on the output channel after the last voxel of the volume, once that voxel leaves the
// compute register. The sustained rate is one voxel per cycle, set by the single read
// and single write per voxel of the slice memory (MAX_WIDTH*MAX_HEIGHT bits)
// and of the row memory (MAX_WIDTH x 2 bits), whose read data is registered at the edge
// that takes the voxel. The input stalls only while a finished sum waits at the output
// and the next sum is due. Writing a dimension restarts the scan; memories need no
// clearing since reads are gated by position. Configure only while the block is idle.
module voxel_euler_octant_sum_top import veos_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [PADDR_W-1:0]         paddr,
  input  logic [PDATA_W-1:0]         pwdata,
  output logic [PDATA_W-1:0]         prdata,
  output logic                       pready,
  // voxel input
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  // result output
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [SUM_W-1:0]    euler_eighths_o
);

  typedef struct packed {
    logic hl;
    logic hu;
    logic hp;
    logic lx;
    logic ly;
    logic lz;
  } pos_flags_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [PDATA_W-1:0] v, input int maxv);
    logic [DIM_W-1:0] u;
    u = v[DIM_W-1:0];
    if (u == '0) begin
      u = DIM_W'(1);
    end else if (int'(u) > maxv) begin
      u = DIM_W'(maxv);
    end
    return u;
  endfunction

  // configuration registers
  logic signed [SAMPLE_W-1:0] thr_lo_q, thr_hi_q;
  logic [DIM_W-1:0]           dim_w_q, dim_h_q, dim_d_q;
  logic [2:0]                 reg_idx;
  logic                       cfg_we, dim_we;

  // scan position of the next voxel to be taken
  logic [XW-1:0] x_q;
  logic [YW-1:0] y_q;
  logic [ZW-1:0] z_q;
  logic [AW-1:0] addr_q;
  pos_flags_t    flags_in;

  // compute register
  logic                       s1_valid_q;
  logic signed [SAMPLE_W-1:0] s1_sample_q;
  pos_flags_t                 s1_flags_q;
  logic [XW-1:0]              s1_x_q;
  logic [AW-1:0]              s1_addr_q;
  logic                       plane_rd_q;
  logic [1:0]                 line_rd_q;

  // previous voxel of the same row
  logic prev_f_q, prev_pxy_q, prev_pxu_q, prev_cu_q;

  logic signed [SUM_W-1:0] acc_q, acc_sum;
  logic signed [SUM_W-1:0] out_q;
  logic                    out_valid_q;

  logic              in_acc, fire, s1_last;
  logic              fg, pxy, pxu, plx, plu, cu, clu, cl;
  logic [7:0]        mask [8];
  logic [7:0]        vert_en;
  logic signed [DSUM_W-1:0] dsum;

  // memories
  logic       plane_mem [PLANE_DEPTH];
  logic [1:0] line_mem  [MAX_WIDTH];

  // apb decode
  assign reg_idx = paddr[4:2];
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign dim_we  = cfg_we && (reg_idx == REG_WIDTH || reg_idx == REG_HEIGHT ||
                              reg_idx == REG_DEPTH);

  always_comb begin
    case (reg_idx)
      REG_THR_LOW:  prdata = {{(PDATA_W-SAMPLE_W){thr_lo_q[SAMPLE_W-1]}}, thr_lo_q};
      REG_THR_HIGH: prdata = {{(PDATA_W-SAMPLE_W){thr_hi_q[SAMPLE_W-1]}}, thr_hi_q};
      REG_WIDTH:    prdata = PDATA_W'(dim_w_q);
      REG_HEIGHT:   prdata = PDATA_W'(dim_h_q);
      REG_DEPTH:    prdata = PDATA_W'(dim_d_q);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_lo_q <= '0;
      thr_hi_q <= 16'sh7fff;
      dim_w_q  <= DIM_W'(1);
      dim_h_q  <= DIM_W'(1);
      dim_d_q  <= DIM_W'(1);
    end else if (cfg_we) begin
      case (reg_idx)
        REG_THR_LOW:  thr_lo_q <= pwdata[SAMPLE_W-1:0];
        REG_THR_HIGH: thr_hi_q <= pwdata[SAMPLE_W-1:0];
        REG_WIDTH:    dim_w_q  <= clamp_dim(pwdata, MAX_WIDTH);
        REG_HEIGHT:   dim_h_q  <= clamp_dim(pwdata, MAX_HEIGHT);
        REG_DEPTH:    dim_d_q  <= clamp_dim(pwdata, MAX_DEPTH);
        default: ;
      endcase
    end
  end

  // handshake: the compute register moves on unless a sum is due and the output is full
  assign s1_last    = s1_flags_q.lx && s1_flags_q.ly && s1_flags_q.lz;
  assign fire       = s1_valid_q && (!s1_last || !out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !fire;
  assign in_acc     = in_valid_i && !in_stall_o;

  // position flags of the voxel being taken
  always_comb begin
    flags_in.hl = (x_q != '0);
    flags_in.hu = (y_q != '0);
    flags_in.hp = (z_q != '0);
    flags_in.lx = ((int'(x_q) + 1) == int'(dim_w_q));
    flags_in.ly = ((int'(y_q) + 1) == int'(dim_h_q));
    flags_in.lz = ((int'(z_q) + 1) == int'(dim_d_q));
  end

  // scan counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q    <= '0;
      y_q    <= '0;
      z_q    <= '0;
      addr_q <= '0;
    end else if (dim_we) begin
      x_q    <= '0;
      y_q    <= '0;
      z_q    <= '0;
      addr_q <= '0;
    end else if (in_acc) begin
      if (flags_in.lx) begin
        x_q <= '0;
        if (flags_in.ly) begin
          y_q    <= '0;
          addr_q <= '0;
          if (flags_in.lz) begin
            z_q <= '0;
          end else begin
            z_q <= z_q + 1'b1;
          end
        end else begin
          y_q    <= y_q + 1'b1;
          addr_q <= addr_q + 1'b1;
        end
      end else begin
        x_q    <= x_q + 1'b1;
        addr_q <= addr_q + 1'b1;
      end
    end
  end

  // compute register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  // compute register payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_sample_q <= sample_i;
      s1_flags_q  <= flags_in;
      s1_x_q      <= x_q;
      s1_addr_q   <= addr_q;
    end
  end

  // slice memory: previous slice at this voxel, replaced by this slice's bit
  always_ff @(posedge clk_i) begin
    if (fire) begin
      plane_mem[s1_addr_q] <= fg;
    end
    if (in_acc) begin
      plane_rd_q <= (fire && s1_addr_q == addr_q) ? fg : plane_mem[addr_q];
    end
  end

  // row memory: {this slice row above, previous slice row above}
  always_ff @(posedge clk_i) begin
    if (fire) begin
      line_mem[s1_x_q] <= {fg, pxy};
    end
    if (in_acc) begin
      line_rd_q <= (fire && s1_x_q == x_q) ? {fg, pxy} : line_mem[x_q];
    end
  end

  // octant corners, gated to background outside the volume
  always_comb begin
    fg  = (s1_sample_q > thr_lo_q) && (s1_sample_q < thr_hi_q);
    pxy = s1_flags_q.hp && plane_rd_q;
    pxu = s1_flags_q.hp && s1_flags_q.hu && line_rd_q[0];
    cu  = s1_flags_q.hu && line_rd_q[1];
    plx = s1_flags_q.hp && s1_flags_q.hl && prev_pxy_q;
    plu = s1_flags_q.hp && s1_flags_q.hl && s1_flags_q.hu && prev_pxu_q;
    clu = s1_flags_q.hu && s1_flags_q.hl && prev_cu_q;
    cl  = s1_flags_q.hl && prev_f_q;
  end

  // the vertex before this voxel, plus the far-face vertices beyond it
  always_comb begin
    mask[0] = {fg, cu, cl, clu, pxy, pxu, plx, plu};
    mask[1] = {2'b00, fg, cu, 2'b00, pxy, pxu};
    mask[2] = {1'b0, fg, 1'b0, cl, 1'b0, pxy, 1'b0, plx};
    mask[3] = {3'b000, fg, 3'b000, pxy};
    mask[4] = {4'b0000, fg, cu, cl, clu};
    mask[5] = {6'b000000, fg, cu};
    mask[6] = {5'b00000, fg, 1'b0, cl};
    mask[7] = {7'b0000000, fg};
    vert_en[0] = 1'b1;
    vert_en[1] = s1_flags_q.lx;
    vert_en[2] = s1_flags_q.ly;
    vert_en[3] = s1_flags_q.lx && s1_flags_q.ly;
    vert_en[4] = s1_flags_q.lz;
    vert_en[5] = s1_flags_q.lz && s1_flags_q.lx;
    vert_en[6] = s1_flags_q.lz && s1_flags_q.ly;
    vert_en[7] = s1_flags_q.lz && s1_flags_q.lx && s1_flags_q.ly;
  end

  // sum of the table entries for this voxel
  always_comb begin
    logic signed [3:0] d;
    dsum = '0;
    for (int i = 0; i < 8; i++) begin
      d = vert_en[i] ? octant_delta(mask[i]) : 4'sd0;
      dsum = dsum + DSUM_W'(d);
    end
  end

  assign acc_sum = acc_q + {{(SUM_W-DSUM_W){dsum[DSUM_W-1]}}, dsum};

  // previous voxel bits
  always_ff @(posedge clk_i) begin
    if (fire) begin
      prev_f_q   <= fg;
      prev_pxy_q <= pxy;
      prev_pxu_q <= pxu;
      prev_cu_q  <= cu;
    end
  end

  // accumulator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (dim_we) begin
      acc_q <= '0;
    end else if (fire) begin
      acc_q <= s1_last ? '0 : acc_sum;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && s1_last) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && s1_last) begin
      out_q <= acc_sum;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign euler_eighths_o = out_q;

endmodule

>>> rtl/veos_checker.sv
module veos_checker import veos_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_stall_o,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic signed [SUM_W-1:0] euler_eighths_o
);

  // a stalled result beat stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // a stalled result beat keeps its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(euler_eighths_o))
    else $error("result value changed while stalled");

  // the input only backs up behind a waiting result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with the result register empty");

  // a new result follows the voxel beat taken ahead of the compute and result registers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result appeared without a preceding voxel beat");

endmodule

bind voxel_euler_octant_sum_top veos_checker u_veos_checker (.*);
